// ===== src/utf8_to_utf16le_decoder_defines.svh =====
// Assertion macros for the UTF-8 to UTF-16LE decoder.
// Used by the queue and back-end modules; no dependencies.
// The clock clk_i and the reset rst_ni are taken from the module that uses them.
`ifndef UTF8_TO_UTF16LE_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16LE_DECODER_DEFINES_SVH

// Check that cond holds at every clock edge out of reset.
`define U8D_ASSERT_HOLD(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("u8d assertion failed");

// Check that cons holds in the cycle where ante holds.
`define U8D_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("u8d assertion failed");

`endif

// ===== src/u8d_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 to UTF-16LE decoder.
// No dependencies.
package u8d_pkg;

  typedef enum logic [1:0] {
    KindUnit  = 2'd0,
    KindEnd   = 2'd1,
    KindError = 2'd2
  } kind_e;

  // Byte ranges of UTF-8 lead and follow bytes.
  localparam logic [7:0] ContMin      = 8'h80;
  localparam logic [7:0] TwoLeadMin   = 8'hC0;
  localparam logic [7:0] ThreeLeadMin = 8'hE0;
  localparam logic [7:0] FourLeadMin  = 8'hF0;

  // One queued entry: an optional code unit followed by an optional marker.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_unit;
    logic        has_mark;
    kind_e       mark_kind;
    logic        mark_eos;
  } entry_t;

endpackage

// ===== src/u8d_byte_if.sv =====
`timescale 1ns / 1ps
// Input channel of the decoder: one UTF-8 byte per word.
// No dependencies.
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

// ===== src/u8d_unit_if.sv =====
`timescale 1ns / 1ps
// Output channel of the decoder: one code unit or marker per word.
// No dependencies.
interface u8d_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [1:0]  kind;
  logic        end_of_string;

  modport source (output valid, output code_unit, output kind, output end_of_string,
                  input ready);
  modport sink (input valid, input code_unit, input kind, input end_of_string,
                output ready);
endinterface

// ===== src/u8d_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts UTF-8 bytes, tracks the sequence state, builds queue entries.
// Depends on u8d_pkg and u8d_byte_if.
module u8d_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  u8d_byte_if.sink         in_byte_i,
  input  logic             q_full_i,
  output logic             push_o,
  output u8d_pkg::entry_t  entry_o
);
  import u8d_pkg::*;

  logic [15:0] partial_q, partial_d;
  logic [1:0]  owed_q, owed_d;
  logic        halted_q, halted_d;
  logic        accept;

  always_comb begin
    logic [7:0]  b;
    logic        last;
    logic        bad;
    logic [15:0] merged;
    b         = in_byte_i.byte_in;
    last      = in_byte_i.last_byte;
    bad       = 1'b0;
    merged    = partial_q;
    partial_d = partial_q;
    owed_d    = owed_q;
    halted_d  = halted_q;
    entry_o   = '{code_unit: 16'h0000, has_unit: 1'b0, has_mark: 1'b0,
                  mark_kind: KindEnd, mark_eos: 1'b0};

    if (halted_q) begin
      // Skip bytes until the last one, which closes with an error marker.
      if (last) begin
        entry_o.has_mark  = 1'b1;
        entry_o.mark_kind = KindError;
        entry_o.mark_eos  = 1'b1;
        partial_d         = '0;
        owed_d            = '0;
        halted_d          = 1'b0;
      end
    end else begin
      if (owed_q == 2'd0) begin
        if (b < ContMin) begin
          entry_o.has_unit  = 1'b1;
          entry_o.code_unit = {8'h00, b};
        end else if (b < TwoLeadMin) begin
          bad = 1'b1;
        end else if (b < ThreeLeadMin) begin
          partial_d = {5'b0_0000, b[4:0], 6'b00_0000};
          owed_d    = 2'd1;
        end else if (b < FourLeadMin) begin
          partial_d = {b[3:0], 12'h000};
          owed_d    = 2'd2;
        end else begin
          bad = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        bad = 1'b1;
      end else begin
        if (owed_q == 2'd2) merged = partial_q | {4'h0, b[5:0], 6'b00_0000};
        else                merged = partial_q | {10'b00_0000_0000, b[5:0]};
        owed_d    = owed_q - 2'd1;
        partial_d = merged;
        if (owed_d == 2'd0) begin
          entry_o.has_unit  = 1'b1;
          entry_o.code_unit = merged;
          partial_d         = '0;
        end
      end

      // A string that ends inside a sequence is cut short.
      if (!bad && last && owed_d != 2'd0) bad = 1'b1;

      if (bad) begin
        entry_o.has_unit  = 1'b0;
        entry_o.has_mark  = 1'b1;
        entry_o.mark_kind = KindError;
        entry_o.mark_eos  = last;
        partial_d         = '0;
        owed_d            = '0;
        halted_d          = !last;
      end else if (last) begin
        entry_o.has_mark  = 1'b1;
        entry_o.mark_kind = KindEnd;
        entry_o.mark_eos  = 1'b1;
        partial_d         = '0;
        owed_d            = '0;
        halted_d          = 1'b0;
      end
    end
  end

  assign in_byte_i.ready = !q_full_i;
  assign accept          = in_byte_i.valid && !q_full_i;
  assign push_o          = accept && (entry_o.has_unit || entry_o.has_mark);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      owed_q    <= '0;
      halted_q  <= 1'b0;
    end else if (accept) begin
      partial_q <= partial_d;
      owed_q    <= owed_d;
      halted_q  <= halted_d;
    end
  end

endmodule

// ===== src/u8d_queue.sv =====
`timescale 1ns / 1ps
// Short entry queue between the front end and the back end.
// Depends on u8d_pkg and utf8_to_utf16le_decoder_defines.svh.
`include "utf8_to_utf16le_decoder_defines.svh"
module u8d_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  u8d_pkg::entry_t  entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output u8d_pkg::entry_t  entry_o,
  output logic             empty_o
);
  import u8d_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= advance(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= advance(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

  `U8D_ASSERT_HOLD(a_count_bound, count_q <= CntW'(Depth))
  `U8D_ASSERT_IMPL(a_no_pop_empty, pop_i, !empty_o)
  `U8D_ASSERT_IMPL(a_no_push_full, push_i, !full_o)

endmodule

// ===== src/u8d_back.sv =====
`timescale 1ns / 1ps
// Back end: drains queue entries into the registered output, one word per cycle while the receiver is ready.
// Depends on u8d_pkg, u8d_unit_if and utf8_to_utf16le_decoder_defines.svh.
`include "utf8_to_utf16le_decoder_defines.svh"
module u8d_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  u8d_pkg::entry_t  entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  u8d_unit_if.source       out_unit_o
);
  import u8d_pkg::*;

  logic        out_valid_q;
  logic        unit_sent_q;
  logic [15:0] code_q;
  kind_e       kind_q;
  logic        eos_q;
  logic        load;
  logic        emit_unit;

  // Send the unit first; hold the entry if a marker still follows it.
  assign load      = !empty_i && (!out_valid_q || out_unit_o.ready);
  assign emit_unit = entry_i.has_unit && !unit_sent_q;
  assign pop_o     = load && (!emit_unit || !entry_i.has_mark);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      unit_sent_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      unit_sent_q <= emit_unit && entry_i.has_mark;
    end else if (out_unit_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= emit_unit ? entry_i.code_unit : 16'h0000;
      kind_q <= emit_unit ? KindUnit : entry_i.mark_kind;
      eos_q  <= emit_unit ? 1'b0 : entry_i.mark_eos;
    end
  end

  assign out_unit_o.valid         = out_valid_q;
  assign out_unit_o.code_unit     = code_q;
  assign out_unit_o.kind          = kind_q;
  assign out_unit_o.end_of_string = eos_q;

  `U8D_ASSERT_IMPL(a_unit_not_eos, out_valid_q && kind_q == KindUnit, !eos_q)
  `U8D_ASSERT_IMPL(a_mark_zero, out_valid_q && kind_q != KindUnit, code_q == 16'h0000)
  `U8D_ASSERT_IMPL(a_held_entry, unit_sent_q, !empty_i && entry_i.has_mark)

endmodule

// ===== src/utf8_to_utf16le_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the UTF-8 to UTF-16LE stream decoder.
// Depends on u8d_pkg, u8d_byte_if, u8d_unit_if, u8d_front, u8d_queue, u8d_back.
//
//   Channel      Dir  Word                                  Handshake
//   in_byte_i    in   byte_in[7:0], last_byte                valid/ready
//   out_unit_o   out  code_unit[15:0], kind[1:0], end_of_string   valid/ready
//
// Cycles: one byte accepted per cycle while the queue is not full; the front end updates the sequence
//   state in the same cycle as it accepts the byte.
// A byte that yields a unit and the end marker gives two output words; the
//   output register sets the sustained result rate of one word/cycle when ready.
// The accepting edge writes the byte's entry into the queue; the back end then
//   loads the output register from the queue once the output is free.
// Reset clears the sequence state, the queue pointers and the output valid.
// Stalls: the queue absorbs output stalls; input ready drops only when it fills.
module utf8_to_utf16le_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8d_byte_if.sink    in_byte_i,
  u8d_unit_if.source  out_unit_o
);
  import u8d_pkg::*;

  // Front end to queue.
  logic   push;
  entry_t push_entry;
  logic   q_full;

  // Queue to back end.
  entry_t head_entry;
  logic   q_empty;
  logic   pop;

  // Classify each byte and advance the partial unit / owed count.
  u8d_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_byte_i (in_byte_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  // Decouple the two sides so either may stall on its own.
  u8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (q_empty)
  );

  // Expand each entry into one or two output words.
  u8d_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (head_entry),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .out_unit_o (out_unit_o)
  );

endmodule

// ===== dv/utf8_to_utf16le_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 to UTF-16LE stream decoder.
// Depends on u8d_pkg, u8d_byte_if, u8d_unit_if and utf8_to_utf16le_decoder.
module utf8_to_utf16le_decoder_test;
  import u8d_pkg::*;

  // One output word as the decoder should present it.
  typedef struct packed {
    logic [15:0] code_unit;
    kind_e       kind;
    logic        eos;
  } unit_word_t;

  // One directed input word. Rows with fixed set carry their expected words
  // inline; the rest take whatever the string predictor works out.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fixed;
    logic [1:0] count;
    unit_word_t first;
    unit_word_t second;
  } stim_row_t;

  localparam int unsigned TotalBytes  = 450;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned ReportLimit = 10;

  localparam unit_word_t NoWord  = '{16'h0000, KindUnit, 1'b0};
  localparam unit_word_t ErrMid  = '{16'h0000, KindError, 1'b0};
  localparam unit_word_t ErrLast = '{16'h0000, KindError, 1'b1};
  localparam unit_word_t EndMark = '{16'h0000, KindEnd, 1'b1};

  localparam stim_row_t DirectedRows [25] = '{
    // smallest and largest one-byte units straight out of reset
    '{8'h00, 1'b0, 1'b1, 2'd1, '{16'h0000, KindUnit, 1'b0}, NoWord},
    '{8'h7F, 1'b0, 1'b1, 2'd1, '{16'h007F, KindUnit, 1'b0}, NoWord},
    // two-byte sequence: the lead alone gives nothing
    '{8'hC2, 1'b0, 1'b1, 2'd0, NoWord, NoWord},
    '{8'hA9, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    '{8'hDF, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    '{8'hBF, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    // three-byte sequences, the last one is the largest unit and closes the string
    '{8'hE2, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    '{8'h82, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    '{8'hAC, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    '{8'hEF, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    '{8'hBF, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    '{8'hBF, 1'b1, 1'b1, 2'd2, '{16'hFFFF, KindUnit, 1'b0}, EndMark},
    // stray continuation, then skipped bytes until the last one
    '{8'h80, 1'b0, 1'b1, 2'd1, ErrMid, NoWord},
    '{8'h41, 1'b0, 1'b1, 2'd0, NoWord, NoWord},
    '{8'h42, 1'b1, 1'b1, 2'd1, ErrLast, NoWord},
    // four-byte lead as a whole string
    '{8'hF0, 1'b1, 1'b1, 2'd1, ErrLast, NoWord},
    // top byte value mid-string
    '{8'hFF, 1'b0, 1'b1, 2'd1, ErrMid, NoWord},
    '{8'h00, 1'b1, 1'b1, 2'd1, ErrLast, NoWord},
    // bad follow byte drops the unfinished unit
    '{8'hE0, 1'b0, 1'b1, 2'd0, NoWord, NoWord},
    '{8'h41, 1'b0, 1'b1, 2'd1, ErrMid, NoWord},
    '{8'h20, 1'b1, 1'b1, 2'd1, ErrLast, NoWord},
    // string cut short right after a lead
    '{8'hC3, 1'b1, 1'b1, 2'd1, ErrLast, NoWord},
    // unit completed by the last byte, then the end marker
    '{8'h41, 1'b1, 1'b1, 2'd2, '{16'h0041, KindUnit, 1'b0}, EndMark},
    // three-byte sequence cut short after one follow byte
    '{8'hE1, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    '{8'hBF, 1'b1, 1'b1, 2'd1, ErrLast, NoWord}
  };

  logic clk_i;
  logic rst_ni;

  u8d_byte_if byte_ch ();
  u8d_unit_if unit_ch ();

  utf8_to_utf16le_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (byte_ch),
    .out_unit_o (unit_ch)
  );

  // Predictor state: mirrors the sequence state of one string.
  logic [15:0] unit_acc;
  logic [1:0]  follow_owed;
  logic        skipping;

  unit_word_t  pending_units [$];

  int unsigned bytes_fed;
  int unsigned strings_fed;
  int unsigned words_checked;
  int unsigned fault_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Work out the words one accepted byte causes and queue them.
  function automatic void predict_units(input logic [7:0] data, input logic last);
    logic bad;
    bad = 1'b0;
    // After an error only the last byte speaks up, with a closing error marker.
    if (skipping) begin
      if (last) begin
        pending_units.push_back(ErrLast);
        unit_acc    = '0;
        follow_owed = '0;
        skipping    = 1'b0;
      end
      return;
    end
    if (follow_owed == 2'd0) begin
      if (data < ContMin) begin
        pending_units.push_back('{{8'h00, data}, KindUnit, 1'b0});
      end else if (data < TwoLeadMin) begin
        bad = 1'b1;                       // continuation with nothing owed
      end else if (data < ThreeLeadMin) begin
        unit_acc    = {5'b0, data[4:0], 6'b0};
        follow_owed = 2'd1;
      end else if (data < FourLeadMin) begin
        unit_acc    = {data[3:0], 12'b0};
        follow_owed = 2'd2;
      end else begin
        bad = 1'b1;                       // four-byte and longer leads
      end
    end else if (data[7:6] != 2'b10) begin
      bad = 1'b1;                         // follow byte outside the continuation range
    end else begin
      // The first of two follow bytes fills bits 11:6, the final one bits 5:0.
      if (follow_owed == 2'd2) unit_acc = unit_acc | {4'b0, data[5:0], 6'b0};
      else unit_acc = unit_acc | {10'b0, data[5:0]};
      follow_owed = follow_owed - 2'd1;
      if (follow_owed == 2'd0) begin
        pending_units.push_back('{unit_acc, KindUnit, 1'b0});
        unit_acc = '0;
      end
    end
    // A last byte that leaves follow bytes owed cuts the string short.
    if (!bad && last && follow_owed != 2'd0) bad = 1'b1;
    if (bad) begin
      pending_units.push_back('{16'h0000, KindError, last});
      unit_acc    = '0;
      follow_owed = '0;
      skipping    = !last;
    end else if (last) begin
      pending_units.push_back(EndMark);
      unit_acc    = '0;
      follow_owed = '0;
      skipping    = 1'b0;
    end
  endfunction

  // Offer one byte, hold it until accepted, then queue its expected words.
  // Fixed rows replace the predicted words with the ones typed in the table.
  task automatic feed_byte(input logic [7:0] data, input logic last, input logic fixed,
                           input logic [1:0] count, input unit_word_t first,
                           input unit_word_t second);
    int unsigned depth_before;
    // Idle mix: sender light and receiver heavy, then swapped, then none.
    case (bytes_fed * 3 / TotalBytes)
      0: begin
        src_idle_pct  = 15;
        sink_idle_pct = 64;
      end
      1: begin
        src_idle_pct  = 64;
        sink_idle_pct = 15;
      end
      default: begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
    endcase
    while ($urandom_range(0, 99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.byte_in   <= data;
    byte_ch.last_byte <= last;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    bytes_fed++;
    depth_before = pending_units.size();
    predict_units(data, last);
    if (fixed) begin
      while (pending_units.size() > depth_before) void'(pending_units.pop_back());
      if (count > 2'd0) pending_units.push_back(first);
      if (count > 2'd1) pending_units.push_back(second);
    end
  endtask

  // Build one random string. Most are well formed with random content; the
  // rest are pure noise, carry one corrupted byte, or lose their final byte.
  task automatic feed_random_string();
    logic [7:0]  seq [$];
    int unsigned mode;
    int unsigned width;
    mode = $urandom_range(0, 99);
    if (mode < 10) begin
      repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) begin
        width = $urandom_range(1, 3);
        case (width)
          1: seq.push_back(8'($urandom_range(0, 127)));
          2: begin
            seq.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
          end
          default: begin
            seq.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
            seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
          end
        endcase
      end
      if (mode < 20) seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
      else if (mode < 28 && seq.size() > 1) void'(seq.pop_back());
    end
    foreach (seq[k]) feed_byte(seq[k], k == seq.size() - 1, 1'b0, 2'd0, NoWord, NoWord);
    strings_fed++;
  endtask

  // Receiver: check every accepted word against the oldest expectation and
  // drop ready at random by the current idle mix.
  initial begin : unit_sink
    unit_word_t want;
    unit_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && unit_ch.valid && unit_ch.ready) begin
        words_checked++;
        if (pending_units.size() == 0) begin
          fault_count++;
          if (fault_count <= ReportLimit)
            $display("unexpected word: unit %h kind %0d eos %b", unit_ch.code_unit,
                     unit_ch.kind, unit_ch.end_of_string);
        end else begin
          want = pending_units.pop_front();
          if (want.code_unit !== unit_ch.code_unit || want.kind !== unit_ch.kind ||
              want.eos !== unit_ch.end_of_string) begin
            fault_count++;
            if (fault_count <= ReportLimit)
              $display("mismatch: expected unit %h kind %0d eos %b, got unit %h kind %0d eos %b",
                       want.code_unit, want.kind, want.eos, unit_ch.code_unit, unit_ch.kind,
                       unit_ch.end_of_string);
          end
        end
      end
      unit_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Cycle counter: stop a hung run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still pending", cycle_count,
             pending_units.size());
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    unit_acc          = '0;
    follow_owed       = '0;
    skipping          = 1'b0;
    bytes_fed         = 0;
    strings_fed       = 0;
    words_checked     = 0;
    fault_count       = 0;
    src_idle_pct      = 0;
    sink_idle_pct     = 0;
    rst_ni            <= 1'b0;
    byte_ch.valid     <= 1'b0;
    byte_ch.byte_in   <= 8'h00;
    byte_ch.last_byte <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table, then random strings until the byte budget is spent.
    foreach (DirectedRows[i])
      feed_byte(DirectedRows[i].data, DirectedRows[i].last, DirectedRows[i].fixed,
                DirectedRows[i].count, DirectedRows[i].first, DirectedRows[i].second);
    while (bytes_fed < TotalBytes) feed_random_string();
    byte_ch.valid <= 1'b0;

    // Drain: wait for every expected word, then a few cycles for strays.
    while (pending_units.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("fed %0d bytes in %0d strings after the directed table under three idle mixes,",
             bytes_fed, strings_fed);
    $display("checked %0d words in %0d cycles, %0d faults", words_checked, cycle_count,
             fault_count);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
